/* design/slwm_pkg.sv */
// Shared types and constants for the stage latency window monitor.
package slwm_pkg;

  localparam int TS_W      = 64;
  localparam int ELAPSED_W = 32;
  localparam int STAGE_W   = 4;
  localparam int FRAMES_W  = 8;
  localparam int KIND_W    = 2;
  localparam int IN_DATA_W  = 72;   // stage + timestamp, padded to bytes
  localparam int OUT_DATA_W = 104;  // three 32-bit stats + frame count

  localparam logic [KIND_W-1:0] REQ_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] REQ_END   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_FRAME = 2'd2;
  localparam logic [KIND_W-1:0] REQ_QUERY = 2'd3;

  typedef struct packed {
    logic load;        // capture the incoming request
    logic start_wr;    // store a stage start time
    logic end_wr;      // write elapsed time into the window store
    logic frame_adv;   // advance frame position and count
    logic query_init;  // clear walk accumulators
    logic walk_rd;     // read next slot of the window
    logic prev_rd;     // read slot before write position
    logic div_start;   // launch the average divide
    logic out_load;    // move result to output register
    logic clr_wr;      // clearing pass write
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] req_type;
    logic              query_live;
    logic              walk_last;
    logic              div_done;
    logic              out_free;
    logic              clr_last;
  } stat_t;

endpackage

/* design/stage_latency_window_monitor.sv */
// Top level of the stage latency window monitor.
//
//  channel   direction  tdata (low bit up)                         tuser
//  s_axis    in         stage[3:0], timestamp_us[67:4], pad to 72   req_type[1:0]
//  m_axis    out        average_us, maximum_us, previous_us,        -
//                       frames_recorded (104 bits)
//
// Begin, end and frame requests are accepted in IDLE and executed in EXEC.
// A query reads the store once per recorded frame, then reads the slot before the write
// position and runs a one-bit-per-cycle divide; when it has no frames or names an unknown
// stage it skips the walk and the divide.
// After reset a clearing pass zeroes all STAGE_SLOTS * WINDOW_FRAMES store words
// (1152 by default) with s_axis_tready low.
// A result waits in the output register; new requests are taken meanwhile, and a later
// query holds in its last cycle until that register is free.
module stage_latency_window_monitor #(
  parameter int WINDOW_FRAMES = 128,
  parameter int STAGE_SLOTS   = 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // stage, timestamp_us, zero pad
  input  logic [1:0]   s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata    // average_us, maximum_us, previous_us, frames_recorded
);
  import slwm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slwm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  slwm_datapath #(
    .WINDOW_FRAMES(WINDOW_FRAMES),
    .STAGE_SLOTS  (STAGE_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .m_tdata  (m_axis_tdata),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready)
  );

endmodule

/* design/slwm_div.sv */
// Restoring divider, one quotient bit per cycle.
module slwm_div #(
  parameter int DW = 40,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          last,
  output logic [DW-1:0] quotient
);
  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW:0]   rem;
  logic [DW-1:0] quot;
  logic [VW-1:0] dvs;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          fits;

  assign rem_sh   = {rem[VW-1:0], quot[DW-1]};
  assign fits     = (rem_sh >= {1'b0, dvs});
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign last     = busy && (cnt == CW'(DW - 1));
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= fits ? rem_sub : rem_sh;
      quot <= {quot[DW-2:0], fits};
    end
  end

endmodule

/* design/slwm_datapath.sv */
// Datapath: request capture, start times, window store, walk, divide, output register.
module slwm_datapath #(
  parameter int WINDOW_FRAMES = 128,
  parameter int STAGE_SLOTS   = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  input  slwm_pkg::cmd_t                   cmd,
  output slwm_pkg::stat_t                  stat,
  input  logic [slwm_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [slwm_pkg::KIND_W-1:0]      s_tuser,
  output logic [slwm_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready
);
  import slwm_pkg::*;

  localparam int DEPTH    = STAGE_SLOTS * WINDOW_FRAMES;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW       = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
  localparam int TW       = $clog2(WINDOW_FRAMES + 1);
  localparam int SUMW     = ELAPSED_W + TW;
  // stage field is 4 bits, so at most 16 start registers are reachable
  localparam int ST_DEPTH = (STAGE_SLOTS < 16) ? STAGE_SLOTS : 16;
  localparam int SW       = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;

  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_ACC  = 2'd1;
  localparam logic [1:0] TAG_PREV = 2'd2;

  // captured request
  logic [KIND_W-1:0]    kind_q;
  logic [STAGE_W-1:0]   stage_q;
  logic [TS_W-1:0]      ts_q;

  logic [TS_W-1:0]      stage_start [ST_DEPTH];
  logic [ELAPSED_W-1:0] mem [DEPTH];

  logic [PW-1:0]        pos;
  logic [TW-1:0]        tally;
  logic [PW-1:0]        idx;
  logic [AW-1:0]        clr_cnt;

  logic [ELAPSED_W-1:0] rd_q;
  logic [1:0]           tag;
  logic [SUMW-1:0]      sum;
  logic [ELAPSED_W-1:0] mx;
  logic [ELAPSED_W-1:0] prev;

  logic                 stage_ok;
  logic                 live;
  logic [SW-1:0]        st_idx;
  logic [AW-1:0]        row_base;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [PW-1:0]        prev_pos;
  logic [TS_W-1:0]      diff;
  logic [ELAPSED_W-1:0] sat;
  logic [SUMW-1:0]      quot;
  logic                 div_last;
  logic [TW+7:0]        tally_ext;

  logic [ELAPSED_W-1:0] avg_o;
  logic [ELAPSED_W-1:0] mx_o;
  logic [ELAPSED_W-1:0] prev_o;
  logic [FRAMES_W-1:0]  frames_o;
  logic                 out_valid;

  assign stage_ok  = ({3'b000, stage_q} < 7'(STAGE_SLOTS));
  assign live      = stage_ok && (tally != '0);
  assign st_idx    = SW'(stage_q);
  assign row_base  = AW'(stage_q) * AW'(WINDOW_FRAMES);
  assign prev_pos  = (pos == '0) ? PW'(WINDOW_FRAMES - 1) : pos - PW'(1);
  assign wr_addr   = row_base + AW'(pos);
  assign rd_addr   = row_base + AW'(cmd.walk_rd ? idx : prev_pos);
  assign diff      = ts_q - stage_start[st_idx];
  assign sat       = (|diff[TS_W-1:ELAPSED_W]) ? '1 : diff[ELAPSED_W-1:0];
  assign tally_ext = {8'h00, tally};

  assign stat.req_type   = kind_q;
  assign stat.query_live = live;
  assign stat.walk_last  = (TW'(idx) == tally - TW'(1));
  assign stat.div_done   = div_last;
  assign stat.out_free   = !out_valid || m_tready;
  assign stat.clr_last   = (clr_cnt == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= s_tuser;
      stage_q <= s_tdata[STAGE_W-1:0];
      ts_q    <= s_tdata[STAGE_W+TS_W-1:STAGE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_wr && stage_ok) begin
      stage_start[st_idx] <= ts_q;
    end
  end

  // single write port shared by the clearing pass and end events
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.end_wr && stage_ok) begin
      mem[wr_addr] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd || cmd.prev_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pos     <= '0;
      tally   <= '0;
      tag     <= TAG_NONE;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.frame_adv) begin
        pos <= (pos == PW'(WINDOW_FRAMES - 1)) ? '0 : pos + PW'(1);
        if (tally != TW'(WINDOW_FRAMES)) begin
          tally <= tally + TW'(1);
        end
      end
      if (cmd.walk_rd) begin
        tag <= TAG_ACC;
      end else if (cmd.prev_rd) begin
        tag <= TAG_PREV;
      end else begin
        tag <= TAG_NONE;
      end
    end
  end

  // read data lands in rd_q in the cycle after the address
  always_ff @(posedge clk) begin
    if (cmd.query_init) begin
      idx  <= '0;
      sum  <= '0;
      mx   <= '0;
      prev <= '0;
    end else begin
      if (cmd.walk_rd) begin
        idx <= idx + PW'(1);
      end
      case (tag)
        TAG_ACC: begin
          sum <= sum + SUMW'(rd_q);
          if (rd_q > mx) begin
            mx <= rd_q;
          end
        end
        TAG_PREV: begin
          prev <= rd_q;
        end
        default: begin
        end
      endcase
    end
  end

  slwm_div #(
    .DW(SUMW),
    .VW(TW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (tally),
    .last     (div_last),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      avg_o    <= live ? quot[ELAPSED_W-1:0] : '0;
      mx_o     <= live ? mx : '0;
      prev_o   <= live ? prev : '0;
      frames_o <= tally_ext[FRAMES_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {frames_o, prev_o, mx_o, avg_o};

endmodule

/* design/slwm_ctrl.sv */
// Controller: sequences clearing, event execution and the query walk.
module slwm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  input  slwm_pkg::stat_t stat,
  output slwm_pkg::cmd_t  cmd
);
  import slwm_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_PREV  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (stat.req_type)
          REQ_BEGIN: cmd.start_wr  = 1'b1;
          REQ_END:   cmd.end_wr    = 1'b1;
          REQ_FRAME: cmd.frame_adv = 1'b1;
          REQ_QUERY: begin
            cmd.query_init = 1'b1;
            state_next     = stat.query_live ? ST_WALK : ST_DONE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_WALK: begin
        cmd.walk_rd = 1'b1;
        if (stat.walk_last) begin
          state_next = ST_PREV;
        end
      end
      ST_PREV: begin
        cmd.prev_rd = 1'b1;
        state_next  = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last walk word was summed on the previous edge
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
